[sv/js_escape_sequence_decoder_defines.svh]
// Assertion macros shared by the escape decoder RTL.
`ifndef JS_ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define JS_ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSESC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("escape decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("escape decoder check failed");

`endif

[sv/jsesc_pkg.sv]
// Types, constants and helpers for the escape decoder.
package jsesc_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned CntW    = 3;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 2;

  localparam logic [CpW-1:0]   CP_MAX        = 21'h10FFFF;
  localparam logic [CpW-1:0]   CP_SUPPLEMENT = 21'h010000;
  localparam logic [5:0]       SURR_HIGH_TAG = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]       SURR_LOW_TAG  = 6'b110111;  // 0xDC00 >> 10
  localparam logic [ModeW-1:0] MODE_RESET    = 2'd1;

  typedef enum logic [ModeW-1:0] {
    MODE_DISABLED = 2'd0,
    MODE_STRING   = 2'd1,
    MODE_REGEXP   = 2'd2,
    MODE_ALT      = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_XHEX    = 4'd1,
    PH_UFIRST  = 4'd2,
    PH_UBRACE  = 4'd3,
    PH_UHEX4   = 4'd4,
    PH_ZLOOK   = 4'd5,
    PH_PAIRBS  = 4'd6,
    PH_PAIRU   = 4'd7,
    PH_PAIRHEX = 4'd8
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_PENDING   = 2'd0,
    ST_DONE      = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_NOTESC    = 2'd3
  } status_e;

  // Character codes.
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    phase_e          phase;
    logic [CpW-1:0]  acc;
    logic [15:0]     high_surr;
    logic [CntW-1:0] digit_cnt;
    logic [CntW-1:0] look_cnt;
  } dec_state_t;

  typedef struct packed {
    status_e         status;
    logic [CpW-1:0]  code_point;
    logic [CntW-1:0] returned;
  } dec_result_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] nibble_of_char(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      r = {1'b1, 4'(c - CH_LO_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

[sv/jsesc_step.sv]
// Next-state and result logic for one character of an escape.
module jsesc_step (
  input  jsesc_pkg::dec_state_t  state_i,
  input  logic [1:0]             mode_i,
  input  logic [7:0]             char_i,
  input  logic                   eoi_i,
  output jsesc_pkg::dec_state_t  state_o,
  output jsesc_pkg::dec_result_t result_o
);
  import jsesc_pkg::*;

  logic [4:0]      hex;
  logic            is_hex;
  logic [3:0]      hv;
  logic            is_dec;
  logic            braces;
  logic            rx;
  logic [15:0]     acc16;
  logic [24:0]     brace_v;
  logic [CntW-1:0] dcnt_inc;
  logic [CntW-1:0] lcnt_inc;
  logic [19:0]     pair_bits;

  assign hex       = nibble_of_char(char_i);
  assign is_hex    = hex[4];
  assign hv        = hex[3:0];
  assign is_dec    = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign braces    = (mode_i != MODE_DISABLED);
  assign rx        = (mode_i == MODE_REGEXP);
  assign acc16     = {state_i.acc[11:0], hv};
  assign brace_v   = {state_i.acc, hv};
  assign dcnt_inc  = state_i.digit_cnt + 3'd1;
  assign lcnt_inc  = state_i.look_cnt + 3'd1;
  assign pair_bits = {state_i.high_surr[9:0], acc16[9:0]};

  always_comb begin
    dec_state_t  ns;
    dec_result_t res;
    ns  = state_i;
    res = '{status: ST_PENDING, code_point: '0, returned: '0};

    case (state_i.phase)
      PH_XHEX: begin
        if (eoi_i || !is_hex) begin
          res.status = ST_MALFORMED;
        end else begin
          ns.acc       = {13'd0, state_i.acc[3:0], hv};
          ns.digit_cnt = dcnt_inc;
          if (dcnt_inc >= 3'd2) begin
            res.status     = ST_DONE;
            res.code_point = {13'd0, state_i.acc[3:0], hv};
          end
        end
      end
      PH_UFIRST: begin
        if (eoi_i) begin
          res.status = ST_MALFORMED;
        end else if (char_i == CH_LBRACE && braces) begin
          ns.phase = PH_UBRACE;
          ns.acc   = '0;
        end else if (!is_hex) begin
          res.status = ST_MALFORMED;
        end else begin
          ns.acc       = {17'd0, hv};
          ns.digit_cnt = 3'd1;
          ns.phase     = PH_UHEX4;
        end
      end
      PH_UBRACE: begin
        if (eoi_i) begin
          res.status = ST_MALFORMED;
        end else if (char_i == CH_RBRACE) begin
          res.status     = ST_DONE;
          res.code_point = state_i.acc;
        end else if (!is_hex) begin
          res.status = ST_MALFORMED;
        end else if (brace_v > {4'd0, CP_MAX}) begin
          res.status = ST_MALFORMED;
        end else begin
          ns.acc = brace_v[CpW-1:0];
        end
      end
      PH_UHEX4: begin
        if (eoi_i || !is_hex) begin
          res.status = ST_MALFORMED;
        end else begin
          ns.acc       = {5'd0, acc16};
          ns.digit_cnt = dcnt_inc;
          if (dcnt_inc >= 3'd4) begin
            if (rx && acc16[15:10] == SURR_HIGH_TAG) begin
              ns.high_surr = acc16;
              ns.look_cnt  = '0;
              ns.phase     = PH_PAIRBS;
            end else begin
              res.status     = ST_DONE;
              res.code_point = {5'd0, acc16};
            end
          end
        end
      end
      PH_ZLOOK: begin
        if (eoi_i) begin
          res.status = ST_DONE;
        end else if (is_dec) begin
          res.status = ST_MALFORMED;
        end else begin
          res.status   = ST_DONE;
          res.returned = 3'd1;
        end
      end
      PH_PAIRBS, PH_PAIRU: begin
        if (eoi_i) begin
          res.status     = ST_DONE;
          res.code_point = {5'd0, state_i.high_surr};
          res.returned   = state_i.look_cnt;
        end else begin
          ns.look_cnt = lcnt_inc;
          if (state_i.phase == PH_PAIRBS && char_i == CH_BSLASH) begin
            ns.phase = PH_PAIRU;
          end else if (state_i.phase == PH_PAIRU && char_i == CH_U) begin
            ns.phase     = PH_PAIRHEX;
            ns.acc       = '0;
            ns.digit_cnt = '0;
          end else begin
            res.status     = ST_DONE;
            res.code_point = {5'd0, state_i.high_surr};
            res.returned   = lcnt_inc;
          end
        end
      end
      PH_PAIRHEX: begin
        if (eoi_i) begin
          res.status     = ST_DONE;
          res.code_point = {5'd0, state_i.high_surr};
          res.returned   = state_i.look_cnt;
        end else begin
          ns.look_cnt = lcnt_inc;
          if (!is_hex) begin
            res.status     = ST_DONE;
            res.code_point = {5'd0, state_i.high_surr};
            res.returned   = lcnt_inc;
          end else begin
            ns.acc       = {5'd0, acc16};
            ns.digit_cnt = dcnt_inc;
            if (dcnt_inc >= 3'd4) begin
              res.status = ST_DONE;
              if (acc16[15:10] == SURR_LOW_TAG) begin
                res.code_point = CP_SUPPLEMENT + {1'b0, pair_bits};
              end else begin
                res.code_point = {5'd0, state_i.high_surr};
                res.returned   = lcnt_inc;
              end
            end
          end
        end
      end
      default: begin
        // Idle, and any unused phase code, takes a new escape letter.
        if (eoi_i) begin
          res.status = ST_MALFORMED;
        end else begin
          case (char_i)
            CH_B: begin res.status = ST_DONE; res.code_point = 21'h08; end
            CH_F: begin res.status = ST_DONE; res.code_point = 21'h0C; end
            CH_N: begin res.status = ST_DONE; res.code_point = 21'h0A; end
            CH_R: begin res.status = ST_DONE; res.code_point = 21'h0D; end
            CH_T: begin res.status = ST_DONE; res.code_point = 21'h09; end
            CH_V: begin res.status = ST_DONE; res.code_point = 21'h0B; end
            CH_X: begin
              ns.phase     = PH_XHEX;
              ns.acc       = '0;
              ns.digit_cnt = '0;
            end
            CH_U: begin
              ns.phase     = PH_UFIRST;
              ns.acc       = '0;
              ns.digit_cnt = '0;
            end
            CH_ZERO: begin
              if (rx) begin
                ns.phase = PH_ZLOOK;
              end else begin
                res.status = ST_MALFORMED;
              end
            end
            default: begin
              if (char_i inside {[CH_ONE:CH_SEVEN]}) begin
                res.status = ST_MALFORMED;
              end else begin
                res.status = ST_NOTESC;
              end
            end
          endcase
        end
      end
    endcase

    if (res.status != ST_PENDING) begin
      ns.phase = PH_IDLE;
    end
    state_o  = ns;
    result_o = res;
  end

endmodule

[sv/js_escape_sequence_decoder.sv]
// Top level of the JavaScript escape decoder: handshakes, state and result register.
// The block takes the characters that follow a backslash, one word per character, and
// returns exactly one result word for every input word: pending while an escape is still
// open, or done, malformed or not an escape, with the code point and the number of
// trailing characters that belong back in the source stream. Each word passes an input
// register and then a single registered decode step, so a word can be accepted in every
// clock cycle while the output side is ready; its result waits in the result register
// until the output side takes it. Throughput is one word per cycle while the output
// is ready; the limit is the decode state itself, which is
// updated once per word in the step between the input and result registers. The mode
// register selects disabled braces, normal string mode or regexp mode with surrogate
// pairing; it resets to normal string mode and should be written only while the block is
// idle. Mode value three behaves as normal string mode.
module js_escape_sequence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Mode register write.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] returned_chars
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import jsesc_pkg::*;
  `include "js_escape_sequence_decoder_defines.svh"

  // Mode register.
  logic [ModeW-1:0] mode_q;

  // Input register stage.
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eoi_q;

  // Decoder state and result register.
  dec_state_t  state_q, state_d;
  dec_result_t step_res;
  dec_result_t out_q;
  logic        out_valid_q;

  logic advance;   // the decode step fires and the result register loads
  logic in_take;

  // The result register can load whenever it is empty or being drained this cycle;
  // the input register then moves on, so a new word can enter at the same edge.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser[0];
    end
  end

  jsesc_step u_step (
    .state_i  (state_q),
    .mode_i   (mode_q),
    .char_i   (in_char_q),
    .eoi_i    (in_eoi_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // The decoder state advances only when a word leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, acc: '0, high_surr: '0, digit_cnt: '0, look_cnt: '0};
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.returned, out_q.code_point};
  assign m_axis_tuser  = out_q.status;

  // Any finished escape leaves the decoder ready for a new escape letter.
  `JSESC_ASSERT_NEXT(a_idle_after_final, clk_i, rst_ni,
    in_valid_q && advance && step_res.status != ST_PENDING, state_q.phase == PH_IDLE)
  // Only a done result carries a code point or returned characters.
  `JSESC_ASSERT_NOW(a_payload_only_done, clk_i, rst_ni,
    out_valid_q && out_q.status != ST_DONE, m_axis_tdata == 24'd0)
  // Results stay within the Unicode range and the lookahead depth.
  `JSESC_ASSERT_NOW(a_result_range, clk_i, rst_ni,
    out_valid_q, out_q.code_point <= CP_MAX && out_q.returned <= 3'd6)
  // The input side stalls only when both stages are full and the output is blocked.
  `JSESC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni,
    !s_axis_tready, in_valid_q && out_valid_q && !m_axis_tready)

endmodule

[tb/tb.sv]
// Self-checking testbench for the JavaScript escape decoder stream block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsesc_pkg::*;

  // Cycles in which neither side moves a word before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_wdata_i   = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;  // [7:0] char_in
  logic [0:0]  s_axis_tuser  = 1'b0;  // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [20:0] code_point, [23:21] returned_chars
  logic [1:0]  m_axis_tuser;          // [1:0] status

  js_escape_sequence_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the decoder state, advanced once per accepted input word.
  logic [1:0]  pred_mode   = MODE_RESET;
  phase_e      pred_phase  = PH_IDLE;
  logic [20:0] pred_acc    = '0;
  logic [15:0] pred_high   = '0;
  logic [2:0]  pred_digits = '0;
  logic [2:0]  pred_look   = '0;

  // Decoded words still owed by the block, oldest first.
  dec_result_t owed_results[$];

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned mode_writes    = 0;
  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  function automatic dec_result_t done_word(input logic [20:0] cp, input logic [2:0] ret);
    dec_result_t r;
    r.status     = ST_DONE;
    r.code_point = cp;
    r.returned   = ret;
    return r;
  endfunction

  // One decode step: consumes a character (or the end marker) and returns the word
  // the block must produce for it.
  function automatic dec_result_t decode_char(input logic [7:0] c, input logic eoi);
    dec_result_t r;
    logic        hex_ok;
    logic [3:0]  nib;
    logic [24:0] wide;
    logic        rx;
    logic        braces;
    r.status     = ST_PENDING;
    r.code_point = '0;
    r.returned   = '0;
    // Digits carry their value in the low nibble; both letter cases sit nine below it.
    hex_ok = 1'b1;
    nib    = c[3:0];
    if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
      nib = c[3:0] + 4'd9;
    end else if (!(c >= CH_ZERO && c <= CH_NINE)) begin
      hex_ok = 1'b0;
    end
    // Mode three falls through to normal string behavior.
    rx     = (pred_mode == MODE_REGEXP);
    braces = (pred_mode != MODE_DISABLED);

    case (pred_phase)
      PH_IDLE: begin
        if (eoi) begin
          r.status = ST_MALFORMED;
        end else begin
          case (c)
            CH_B: r = done_word(21'h08, 3'd0);
            CH_F: r = done_word(21'h0C, 3'd0);
            CH_N: r = done_word(21'h0A, 3'd0);
            CH_R: r = done_word(21'h0D, 3'd0);
            CH_T: r = done_word(21'h09, 3'd0);
            CH_V: r = done_word(21'h0B, 3'd0);
            CH_X: begin
              pred_phase  = PH_XHEX;
              pred_acc    = '0;
              pred_digits = '0;
            end
            CH_U: begin
              pred_phase  = PH_UFIRST;
              pred_acc    = '0;
              pred_digits = '0;
            end
            CH_ZERO: begin
              if (rx) pred_phase = PH_ZLOOK;
              else r.status = ST_MALFORMED;
            end
            default: begin
              if (c >= CH_ONE && c <= CH_SEVEN) r.status = ST_MALFORMED;
              else r.status = ST_NOTESC;
            end
          endcase
        end
      end
      PH_XHEX: begin
        if (eoi || !hex_ok) begin
          r.status = ST_MALFORMED;
        end else begin
          pred_acc = {13'd0, pred_acc[3:0], nib};
          pred_digits++;
          if (pred_digits >= 3'd2) r = done_word(pred_acc, 3'd0);
        end
      end
      PH_UFIRST: begin
        if (eoi) begin
          r.status = ST_MALFORMED;
        end else if (c == CH_LBRACE && braces) begin
          pred_phase = PH_UBRACE;
          pred_acc   = '0;
        end else if (!hex_ok) begin
          r.status = ST_MALFORMED;
        end else begin
          pred_acc    = {17'd0, nib};
          pred_digits = 3'd1;
          pred_phase  = PH_UHEX4;
        end
      end
      PH_UBRACE: begin
        if (eoi) begin
          r.status = ST_MALFORMED;
        end else if (c == CH_RBRACE) begin
          r = done_word(pred_acc, 3'd0);
        end else if (!hex_ok) begin
          r.status = ST_MALFORMED;
        end else begin
          // The digit that pushes the value past the last code point fails at once.
          wide = {pred_acc, nib};
          if (wide > 25'(CP_MAX)) r.status = ST_MALFORMED;
          else pred_acc = wide[20:0];
        end
      end
      PH_UHEX4: begin
        if (eoi || !hex_ok) begin
          r.status = ST_MALFORMED;
        end else begin
          pred_acc = {5'd0, pred_acc[11:0], nib};
          pred_digits++;
          if (pred_digits == 3'd4) begin
            if (rx && pred_acc[15:10] == SURR_HIGH_TAG) begin
              // Hold the high half and look ahead for a low half.
              pred_high  = pred_acc[15:0];
              pred_look  = '0;
              pred_phase = PH_PAIRBS;
            end else begin
              r = done_word(pred_acc, 3'd0);
            end
          end
        end
      end
      PH_ZLOOK: begin
        if (eoi) r = done_word(21'd0, 3'd0);
        else if (c >= CH_ZERO && c <= CH_NINE) r.status = ST_MALFORMED;
        else r = done_word(21'd0, 3'd1);
      end
      PH_PAIRBS, PH_PAIRU: begin
        if (eoi) begin
          r = done_word({5'd0, pred_high}, pred_look);
        end else begin
          pred_look++;
          if (pred_phase == PH_PAIRBS && c == CH_BSLASH) begin
            pred_phase = PH_PAIRU;
          end else if (pred_phase == PH_PAIRU && c == CH_U) begin
            pred_phase  = PH_PAIRHEX;
            pred_acc    = '0;
            pred_digits = '0;
          end else begin
            r = done_word({5'd0, pred_high}, pred_look);
          end
        end
      end
      default: begin
        // Digits of the candidate low half.
        if (eoi) begin
          r = done_word({5'd0, pred_high}, pred_look);
        end else begin
          pred_look++;
          if (!hex_ok) begin
            r = done_word({5'd0, pred_high}, pred_look);
          end else begin
            pred_acc = {5'd0, pred_acc[11:0], nib};
            pred_digits++;
            if (pred_digits == 3'd4) begin
              if (pred_acc[15:10] == SURR_LOW_TAG) begin
                r = done_word(CP_SUPPLEMENT + {1'b0, pred_high[9:0], pred_acc[9:0]}, 3'd0);
              end else begin
                r = done_word({5'd0, pred_high}, pred_look);
              end
            end
          end
        end
      end
    endcase

    if (r.status != ST_PENDING) pred_phase = PH_IDLE;
    return r;
  endfunction

  // Scoreboard: result words are checked before the input word of the same edge is
  // predicted, so a word can never be matched against its own expectation.
  always @(posedge clk_i) begin : scoreboard
    dec_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        status_seen[m_axis_tuser]++;
        if (owed_results.size() == 0) begin
          $error("result word with nothing expected: status %0d tdata %h",
                 m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[20:0] !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, m_axis_tdata[20:0]);
            fail_count++;
          end
          if (m_axis_tdata[23:21] !== want.returned) begin
            $error("returned_chars: expected %0d, got %0d", want.returned,
                   m_axis_tdata[23:21]);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_results.push_back(decode_char(s_axis_tdata, s_axis_tuser[0]));
      end
    end
  end

  // Receiver back-pressure, one fresh decision per cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a run that stops moving words is a failure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, owed_results.size());
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one character word, with random gaps ahead of it, and returns once the
  // block has taken it.
  task automatic send_word(input logic [7:0] c, input logic eoi);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  // Mostly the intended character; now and then a stray byte or an early end.
  task automatic send_noisy(input logic [7:0] c);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) send_end();
    else if (roll < 5) send_word(8'($urandom_range(255)), 1'b0);
    else send_word(c, 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    if ($urandom_range(1)) return CH_UP_A + 8'(n) - 8'd10;
    return CH_LO_A + 8'(n) - 8'd10;
  endfunction

  // Sends the lowest 'digits' nibbles of a value, most significant first.
  task automatic send_hex(input logic [31:0] value, input int digits);
    for (int i = digits - 1; i >= 0; i--) send_noisy(hex_char(value[4*i +: 4]));
  endtask

  // Waits until every owed word has come back and the pipeline has emptied.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input mode_e m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_mode = m;
    mode_writes++;
  endtask

  // Letters, the end marker at the letter, octal digits and bytes at both extremes,
  // all under the mode that reset leaves behind.
  task automatic test_single_letters();
    send_text("bfnrtv");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_end();
    send_text("70");
  endtask

  task automatic test_fixed_hex();
    send_text("xFfx00xg");
    send_text("x");
    send_end();
    send_text("u0000uFFFFu1G");
  endtask

  // Largest code point, unlimited leading zeros, overflow, empty braces, end inside.
  task automatic test_braces();
    send_text("u{10FFFF}u{0000000041}u{110000}u{}u{");
    send_end();
  endtask

  task automatic test_mode_switching();
    set_mode(MODE_DISABLED);
    send_text("u{u0041");
    set_mode(MODE_ALT);
    send_text("u{41}");
    // The register is read on every character, so a change inside an escape counts.
    set_mode(MODE_STRING);
    send_text("u");
    set_mode(MODE_DISABLED);
    send_text("{");
    set_mode(MODE_STRING);
    send_text("uD800");
  endtask

  // Surrogate pairing and every way it can fall apart, plus the zero lookahead.
  task automatic test_regexp_pairs();
    set_mode(MODE_REGEXP);
    send_text("uD83D\\uDE00uDBFF\\uDFFFuDBFFx");
    send_text("uD800\\u1234uD800\\uDCzuD800");
    send_end();
    send_text("uD800\\");
    send_end();
    send_text("0a05x0");
    send_end();
  endtask

  // One escape sequence of a random kind with random content.
  task automatic random_escape();
    int unsigned kind;
    logic [31:0] value;
    int          digits;
    kind = $urandom_range(99);
    if (kind < 10) begin
      case ($urandom_range(5))
        0: send_noisy(CH_B);
        1: send_noisy(CH_F);
        2: send_noisy(CH_N);
        3: send_noisy(CH_R);
        4: send_noisy(CH_T);
        default: send_noisy(CH_V);
      endcase
    end else if (kind < 22) begin
      send_noisy(CH_X);
      send_hex($urandom_range(255), 2);
    end else if (kind < 36) begin
      send_noisy(CH_U);
      send_hex($urandom_range(16'hFFFF), 4);
    end else if (kind < 56) begin
      send_noisy(CH_U);
      send_noisy(CH_LBRACE);
      if ($urandom_range(9) == 0) value = $urandom_range(24'hFFFFFF);
      else if ($urandom_range(3) == 0) value = $urandom_range(255);
      else value = $urandom_range(CP_MAX);
      digits = 0;
      for (logic [31:0] v = value; v != 0; v = v >> 4) digits++;
      if (!(value == 0 && $urandom_range(1))) digits += $urandom_range(2);
      send_hex(value, digits);
      send_noisy(CH_RBRACE);
    end else if (kind < 76) begin
      send_noisy(CH_U);
      send_hex(16'hD800 + $urandom_range(10'h3FF), 4);
      if ($urandom_range(7) != 0) begin
        send_noisy(CH_BSLASH);
        send_noisy(CH_U);
        if ($urandom_range(3) == 0) send_hex($urandom_range(16'hFFFF), 4);
        else send_hex(16'hDC00 + $urandom_range(10'h3FF), 4);
      end
    end else if (kind < 84) begin
      send_noisy(CH_ZERO);
      if ($urandom_range(1)) send_noisy(CH_ZERO + 8'($urandom_range(9)));
      else send_noisy(8'($urandom_range(255)));
    end else if (kind < 88) begin
      send_noisy(CH_ONE + 8'($urandom_range(6)));
    end else if (kind < 95) begin
      send_word(8'($urandom_range(255)), 1'b0);
    end else begin
      send_end();
    end
  endtask

  // Random escapes under one idling profile, with the mode redrawn now and then.
  task automatic test_random_traffic(input int unsigned count, input int unsigned gap,
                                     input int unsigned stall);
    int unsigned stop_at;
    int unsigned next_mode_at;
    int unsigned pick;
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    stop_at        = words_sent + count;
    next_mode_at   = words_sent;
    while (words_sent < stop_at) begin
      if (words_sent >= next_mode_at) begin
        pick = $urandom_range(9);
        if (pick < 2) set_mode(MODE_DISABLED);
        else if (pick < 4) set_mode(MODE_STRING);
        else if (pick < 8) set_mode(MODE_REGEXP);
        else set_mode(MODE_ALT);
        next_mode_at = words_sent + $urandom_range(40, 100);
      end
      random_escape();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 35;
    recv_stall_pct = 61;
    test_single_letters();
    test_fixed_hex();
    test_braces();
    test_mode_switching();
    test_regexp_pairs();

    test_random_traffic(230, 35, 61);
    test_random_traffic(230, 61, 35);
    test_random_traffic(232, 0, 0);

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d character words over %0d mode writes, all four modes.",
             words_sent, mode_writes);
    $display("Results: %0d pending, %0d done, %0d malformed, %0d not an escape.",
             status_seen[ST_PENDING], status_seen[ST_DONE], status_seen[ST_MALFORMED],
             status_seen[ST_NOTESC]);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
